// ===== rtl/lzwd_pkg.sv =====
// lzwd_pkg: shared types and constants of the lzw stream decompressor
// used by lzwd_ctrl, lzwd_datapath and lzw_stream_decompressor
`default_nettype none

package lzwd_pkg;

  localparam int CODE_END   = 256;
  localparam int CODE_WIDEN = 257;
  localparam int CODE_CLEAR = 258;
  localparam int CODE_FIRST = 259;
  localparam int LIT_MAX    = 255;
  localparam int MIN_WIDTH  = 9;

  typedef enum logic [1:0] {
    MODE_FEED    = 2'd0,
    MODE_FETCH   = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_END     = 3'd1,
    ST_LEN     = 3'd2,
    ST_FULL    = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_LIT   = 3'd0,
    KIND_END   = 3'd1,
    KIND_WIDEN = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_DATA  = 3'd4
  } kind_e;

  typedef struct packed {
    logic    clear_item;
    logic    restart;
    logic    shift_in;
    logic    pop_rd;
    logic    pop_done;
    logic    take_code;
    logic    walk_rd;
    logic    walk_zero;
    logic    walk_push;
    logic    walk_end;
    logic    load_out;
    status_e out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  ended;
    logic  empty;
    logic  len_reached;
    logic  pop_len;
    logic  have_bits;
    kind_e kind;
    logic  walk_more;
    logic  walk_valid;
    logic  dict_full;
    logic  out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/lzwd_ram.sv =====
// lzwd_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/lzwd_ctrl.sv =====
// lzwd_ctrl: sequencer of the lzw decompressor
// depends on lzwd_pkg; drives lzwd_datapath through ctrl_cmd_t
`default_nettype none

module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic [1:0] s_mode_i,
  output logic            s_ready_o,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_POP     = 6'b000010,
    S_DECODE  = 6'b000100,
    S_WALK    = 6'b001000,
    S_WALK_RD = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    ended_q, ended_d;
  logic    dropped_q, dropped_d;
  mode_e   mode;

  assign mode      = mode_e'(s_mode_i);
  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    ended_d   = ended_q;
    dropped_d = dropped_q;
    cmd_o     = '0;
    cmd_o.out_status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.clear_item = 1'b1;
          ended_d   = 1'b0;
          dropped_d = 1'b0;
          status_d  = ST_OK;
          state_d   = S_DONE;
          unique case (mode)
            MODE_RESTART: cmd_o.restart = 1'b1;
            MODE_FEED: begin
              if (sts_i.ended || !sts_i.empty) begin
                status_d = ST_REFUSED;
              end else if (sts_i.len_reached) begin
                status_d = ST_LEN;
              end else begin
                cmd_o.shift_in = 1'b1;
                state_d = S_DECODE;
              end
            end
            MODE_FETCH: begin
              if (sts_i.len_reached) begin
                status_d = ST_LEN;
              end else if (sts_i.empty) begin
                status_d = sts_i.ended ? ST_END : ST_OK;
              end else begin
                cmd_o.pop_rd = 1'b1;
                state_d = S_POP;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        if (sts_i.pop_len) begin
          status_d = ST_LEN;
          state_d  = S_DONE;
        end else begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.empty && !sts_i.ended && sts_i.have_bits && !sts_i.len_reached) begin
          cmd_o.take_code = 1'b1;
          if (sts_i.kind == KIND_END) begin
            ended_d = 1'b1;
          end
          if (sts_i.kind == KIND_DATA) begin
            state_d = S_WALK;
          end
        end else begin
          status_d = ended_q ? ST_END : (dropped_q ? ST_FULL : ST_OK);
          state_d  = S_DONE;
        end
      end
      S_WALK: begin
        if (sts_i.walk_more) begin
          if (sts_i.walk_valid) begin
            cmd_o.walk_rd = 1'b1;
            state_d = S_WALK_RD;
          end else begin
            cmd_o.walk_zero = 1'b1;
          end
        end else begin
          cmd_o.walk_end = 1'b1;
          if (sts_i.dict_full) begin
            dropped_d = 1'b1;
          end
          state_d = S_DECODE;
        end
      end
      S_WALK_RD: begin
        cmd_o.walk_push = 1'b1;
        state_d = S_WALK;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= ST_OK;
      ended_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      ended_q   <= ended_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lzwd_datapath.sv =====
// lzwd_datapath: bit buffer, dictionary, byte stack and output word register
// depends on lzwd_pkg and lzwd_ram; commanded by lzwd_ctrl
`default_nettype none

module lzwd_datapath
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16,
  parameter int DICT_DEPTH    = 65536,
  parameter int STACK_DEPTH   = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_status_t       sts_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        len_we_i,
  input  wire logic [31:0] len_wdata_i,
  output logic      [31:0] len_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic      [31:0] m_data_o,
  output logic             m_user_o,
  output logic             m_last_o
);

  localparam int CW   = MAX_CODE_BITS;
  localparam int BUFW = MAX_CODE_BITS + 16;
  localparam int CNTW = $clog2(BUFW + 1);
  localparam int WIDW = $clog2(MAX_CODE_BITS + 1);
  localparam int NFW  = $clog2(DICT_DEPTH + 1);
  localparam int DAW  = $clog2(DICT_DEPTH);
  localparam int SDW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int VW   = (CW > NFW) ? CW : NFW;

  logic [BUFW-1:0] buf_q, buf_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [WIDW-1:0] wid_q, wid_d;
  logic [NFW-1:0]  nf_q, nf_d;
  logic [CW-1:0]   prev_q, prev_d;
  logic [7:0]      pfc_q, pfc_d;
  logic            expect_q, expect_d;
  logic [SDW-1:0]  depth_q, depth_d;
  logic [31:0]     emitted_q, emitted_d;
  logic            ended_q, ended_d;
  logic [31:0]     len_q;
  logic [CW-1:0]   v_q, v_d;
  logic [CW-1:0]   cur_q, cur_d;
  logic [7:0]      ob_q, ob_d;
  logic            valid_q, valid_d, last_q, last_d;
  logic            m_valid_q;
  logic [31:0]     m_data_q;
  logic            m_user_q, m_last_q;

  logic [CNTW-1:0]  sh;
  logic [BUFW-1:0]  shifted, keep_mask;
  logic [CW-1:0]    code, code_mask;
  kind_e            kind;
  logic             stack_full;
  logic             st_we;
  logic [7:0]       st_wdata;
  logic [7:0]       st_rdata;
  logic [SAW-1:0]   st_raddr;
  logic             dict_we;
  logic [CW+7:0]    dict_rdata;

  assign sh        = cnt_q - CNTW'(wid_q);
  assign shifted   = buf_q >> sh;
  assign code_mask = ~(~CW'(0) << wid_q);
  assign code      = CW'(shifted) & code_mask;
  assign keep_mask = ~(~BUFW'(0) << sh);
  assign stack_full = (depth_q == SDW'(STACK_DEPTH));

  always_comb begin
    if (expect_q) begin
      kind = KIND_LIT;
    end else if (code == CW'(CODE_END)) begin
      kind = KIND_END;
    end else if (code == CW'(CODE_WIDEN)) begin
      kind = KIND_WIDEN;
    end else if (code == CW'(CODE_CLEAR)) begin
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_DATA;
    end
  end

  always_comb begin
    sts_o.ended       = ended_q;
    sts_o.empty       = (depth_q == '0);
    sts_o.len_reached = (emitted_q >= len_q);
    sts_o.pop_len     = ({1'b0, emitted_q} + 33'd1) >= {1'b0, len_q};
    sts_o.have_bits   = (cnt_q >= CNTW'(wid_q));
    sts_o.kind        = kind;
    sts_o.walk_more   = (v_q > CW'(LIT_MAX)) && !stack_full;
    sts_o.walk_valid  = (VW'(v_q) >= VW'(CODE_FIRST)) && (VW'(v_q) < VW'(nf_q));
    sts_o.dict_full   = (nf_q >= NFW'(DICT_DEPTH));
    sts_o.out_busy    = m_valid_q && !m_ready_i;
  end

  always_comb begin
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    wid_d     = wid_q;
    nf_d      = nf_q;
    prev_d    = prev_q;
    pfc_d     = pfc_q;
    expect_d  = expect_q;
    depth_d   = depth_q;
    emitted_d = emitted_q;
    ended_d   = ended_q;
    v_d       = v_q;
    cur_d     = cur_q;
    ob_d      = ob_q;
    valid_d   = valid_q;
    last_d    = last_q;
    st_we     = 1'b0;
    st_wdata  = pfc_q;
    st_raddr  = SAW'(depth_q - SDW'(1));
    dict_we   = 1'b0;

    if (cmd_i.clear_item) begin
      ob_d    = '0;
      valid_d = 1'b0;
      last_d  = 1'b0;
    end
    if (cmd_i.restart) begin
      buf_d     = '0;
      cnt_d     = '0;
      wid_d     = WIDW'(MIN_WIDTH);
      nf_d      = NFW'(CODE_FIRST);
      prev_d    = '0;
      pfc_d     = '0;
      expect_d  = 1'b1;
      depth_d   = '0;
      emitted_d = '0;
      ended_d   = 1'b0;
    end
    if (cmd_i.shift_in) begin
      buf_d = {buf_q[BUFW-9:0], in_byte_i};
      cnt_d = cnt_q + CNTW'(8);
    end
    if (cmd_i.pop_rd) begin
      depth_d = depth_q - SDW'(1);
    end
    if (cmd_i.pop_done) begin
      ob_d      = st_rdata;
      valid_d   = 1'b1;
      last_d    = (depth_q == '0);
      emitted_d = emitted_q + 32'd1;
    end
    if (cmd_i.take_code) begin
      buf_d = buf_q & keep_mask;
      cnt_d = sh;
      case (kind)
        KIND_LIT: begin
          st_we    = 1'b1;
          st_wdata = code[7:0];
          depth_d  = depth_q + SDW'(1);
          prev_d   = code;
          pfc_d    = code[7:0];
          expect_d = 1'b0;
        end
        KIND_END: ended_d = 1'b1;
        KIND_WIDEN: begin
          if (wid_q < WIDW'(MAX_CODE_BITS)) begin
            wid_d = wid_q + WIDW'(1);
          end
        end
        KIND_CLEAR: begin
          wid_d    = WIDW'(MIN_WIDTH);
          nf_d     = NFW'(CODE_FIRST);
          expect_d = 1'b1;
        end
        default: begin
          cur_d = code;
          if (VW'(code) >= VW'(nf_q)) begin
            st_we    = 1'b1;
            st_wdata = pfc_q;
            depth_d  = depth_q + SDW'(1);
            v_d      = prev_q;
          end else begin
            v_d = code;
          end
        end
      endcase
    end
    if (cmd_i.walk_zero) begin
      v_d = '0;
    end
    if (cmd_i.walk_push) begin
      st_we    = 1'b1;
      st_wdata = dict_rdata[7:0];
      depth_d  = depth_q + SDW'(1);
      v_d      = dict_rdata[CW+7:8];
    end
    if (cmd_i.walk_end) begin
      if (!stack_full) begin
        st_we    = 1'b1;
        st_wdata = v_q[7:0];
        depth_d  = depth_q + SDW'(1);
      end
      if (nf_q < NFW'(DICT_DEPTH)) begin
        dict_we = 1'b1;
        nf_d    = nf_q + NFW'(1);
      end
      prev_d = cur_q;
      pfc_d  = v_q[7:0];
    end
  end

  lzwd_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(SAW'(depth_q)),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  lzwd_ram #(
    .WIDTH(CW + 8),
    .DEPTH(DICT_DEPTH)
  ) u_dict (
    .clk_i  (clk_i),
    .we_i   (dict_we),
    .waddr_i(DAW'(nf_q)),
    .wdata_i({prev_q, v_q[7:0]}),
    .raddr_i(DAW'(v_q)),
    .rdata_o(dict_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= '0;
      cnt_q     <= '0;
      wid_q     <= WIDW'(MIN_WIDTH);
      nf_q      <= NFW'(CODE_FIRST);
      prev_q    <= '0;
      pfc_q     <= '0;
      expect_q  <= 1'b1;
      depth_q   <= '0;
      emitted_q <= '0;
      ended_q   <= 1'b0;
      len_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
      wid_q     <= wid_d;
      nf_q      <= nf_d;
      prev_q    <= prev_d;
      pfc_q     <= pfc_d;
      expect_q  <= expect_d;
      depth_q   <= depth_d;
      emitted_q <= emitted_d;
      ended_q   <= ended_d;
      if (len_we_i) begin
        len_q <= len_wdata_i;
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    cur_q   <= cur_d;
    ob_q    <= ob_d;
    valid_q <= valid_d;
    last_q  <= last_d;
    if (cmd_i.load_out) begin
      m_data_q <= {4'd0, cmd_i.out_status, 17'(depth_q), ob_q};
      m_user_q <= valid_q;
      m_last_q <= last_q;
    end
  end

  assign len_o     = len_q;
  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;
  assign m_last_o  = m_last_q;

endmodule

`default_nettype wire

// ===== rtl/lzw_stream_decompressor.sv =====
// lzw_stream_decompressor: lzw decoder top level, variable code width, msb first
// depends on lzwd_pkg, lzwd_ctrl, lzwd_datapath, lzwd_ram
//
// one word in on the slave stream (tuser selects feed, fetch or restart,
// tdata carries the compressed byte) gives exactly one word out on the
// master stream (decoded byte, valid flag, end-of-string tlast, pending
// count and status). the expected output length is written over apb at
// address 0; the user must write it only while the block is idle, the block
// itself does not enforce it. a feed shifts in its byte, then takes codes
// one at a time while the stack is empty, no end code has come and enough
// bits are buffered; a data code adds a prefix walk, each step of which is
// one dictionary read and one stack write, or a zero in place of an unused
// code. a fetch first reads the stack, then decodes on like a feed, or goes
// straight to its result when it reaches the output length. one item is in work at a time.
// a new item is taken while the previous result waits in the output
// register; if the receiver stalls, the block holds in its last cycle.
// reset clears the bit buffer and counters and empties the stack; the
// dictionary and stack rams are not cleared and need no sweep.
`default_nettype none

module lzw_stream_decompressor
  import lzwd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 16,
  parameter int DICT_DEPTH    = 65536,
  parameter int STACK_DEPTH   = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // in_byte[7:0]
  input  wire logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,  // out_byte[7:0], pending_count[24:8], status[27:25]
  output logic             m_axis_tuser_o,  // out_valid[0]
  output logic             m_axis_tlast_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic      [31:0] prdata_o,
  output logic             pready_o
);

  ctrl_cmd_t   cmd;
  dp_status_t  sts;
  logic        len_we;
  logic [31:0] len;

  assign pready_o = 1'b1;
  assign len_we   = psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0);
  assign prdata_o = (paddr_i[2] == 1'b0) ? len : 32'd0;

  lzwd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_mode_i (s_axis_tuser_i),
    .s_ready_o(s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  lzwd_datapath #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .DICT_DEPTH   (DICT_DEPTH),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_byte_i  (s_axis_tdata_i),
    .len_we_i   (len_we),
    .len_wdata_i(pwdata_i),
    .len_o      (len),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_user_o   (m_axis_tuser_o),
    .m_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_lzw_stream_decompressor.sv =====
// tb_lzw_stream_decompressor: self-checking testbench of the lzw stream decompressor
// drives directed rows then random code streams; checks typed rows as given, others
// against a behavioural predictor; depends on lzwd_pkg and lzw_stream_decompressor
`timescale 1ns / 100ps

module tb_lzw_stream_decompressor;
  import lzwd_pkg::*;

  typedef struct {
    logic [7:0]  ob;
    logic        valid;
    logic        last;
    logic [16:0] pend;
    status_e     st;
  } word_t;

  typedef struct {
    bit          is_cfg;
    mode_e       mode;
    logic [7:0]  data;
    logic [31:0] cfg;
    bit          typed;
    word_t       exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         s_tready, m_tvalid, m_tuser, m_tlast, pready;
  wire  [31:0] m_tdata, prdata;

  lzw_stream_decompressor dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  always #5 clk_i = ~clk_i;

  // decoder copy
  int unsigned     len_cfg;
  longint unsigned bbuf;
  int unsigned     bcnt, cwidth, nfree, prev_code, prev_first, sdepth, emitted;
  bit              want_lit, stream_done, end_taken, entry_dropped;
  int unsigned     pfx_tab[65536];
  byte unsigned    sfx_tab[65536];
  byte unsigned    stk[65536];

  word_t       expected_q[$];
  int          errors = 0;
  int          idle_pct = 0, stall_pct = 0;
  int          hold_cnt = 0;
  bit          hold_req = 1'b0;
  int          items = 0;
  row_t        rows[$];

  function automatic void restart_decoder();
    bbuf = 0; bcnt = 0; cwidth = 9; nfree = CODE_FIRST;
    prev_code = 0; prev_first = 0; want_lit = 1'b1;
    sdepth = 0; emitted = 0; stream_done = 1'b0;
  endfunction

  function automatic void push_stk(int unsigned b);
    if (sdepth < 65536) begin
      stk[sdepth] = b[7:0];
      sdepth++;
    end
  endfunction

  function automatic void expand_string(int unsigned code);
    int unsigned v;
    v = code;
    if (code >= nfree) begin
      push_stk(prev_first);
      v = prev_code;
    end
    while (v > LIT_MAX && sdepth < 65536) begin
      if (v >= CODE_FIRST && v < nfree && v < 65536) begin
        push_stk(sfx_tab[v]);
        v = pfx_tab[v];
      end else v = 0;
    end
    push_stk(v);
    if (nfree < 65536) begin
      pfx_tab[nfree] = prev_code;
      sfx_tab[nfree] = v[7:0];
      nfree++;
    end else entry_dropped = 1'b1;
    prev_code = code;
    prev_first = v & 8'hff;
  endfunction

  function automatic void decode_run();
    int unsigned shift, code;
    while (sdepth == 0 && !stream_done && bcnt >= cwidth && emitted < len_cfg) begin
      shift = bcnt - cwidth;
      code = int'((bbuf >> shift) & ((64'd1 << cwidth) - 1));
      bcnt = shift;
      bbuf &= (64'd1 << bcnt) - 1;
      if (want_lit) begin
        push_stk(code);
        prev_code = code;
        prev_first = code & 8'hff;
        want_lit = 1'b0;
      end else if (code == CODE_END) begin
        stream_done = 1'b1;
        end_taken = 1'b1;
      end else if (code == CODE_WIDEN) begin
        if (cwidth < 16) cwidth++;
      end else if (code == CODE_CLEAR) begin
        cwidth = MIN_WIDTH;
        nfree = CODE_FIRST;
        want_lit = 1'b1;
      end else expand_string(code);
    end
  endfunction

  function automatic word_t decode_word(mode_e m, logic [7:0] d);
    word_t r;
    bit run;
    r = '{8'd0, 1'b0, 1'b0, 17'd0, ST_OK};
    run = 1'b0;
    end_taken = 1'b0;
    entry_dropped = 1'b0;
    case (m)
      MODE_RESTART: restart_decoder();
      MODE_FEED: begin
        if (stream_done || sdepth != 0) r.st = ST_REFUSED;
        else if (emitted >= len_cfg) r.st = ST_LEN;
        else begin
          bbuf = (bbuf << 8) | d;
          bcnt += 8;
          run = 1'b1;
        end
      end
      MODE_FETCH: begin
        if (emitted >= len_cfg) r.st = ST_LEN;
        else if (sdepth == 0) r.st = stream_done ? ST_END : ST_OK;
        else begin
          sdepth--;
          r.ob = stk[sdepth];
          r.valid = 1'b1;
          r.last = (sdepth == 0);
          emitted++;
          if (emitted >= len_cfg) r.st = ST_LEN;
          else run = 1'b1;
        end
      end
      default: ;
    endcase
    if (run) begin
      decode_run();
      r.st = end_taken ? ST_END : (entry_dropped ? ST_FULL : ST_OK);
    end
    r.pend = sdepth[16:0];
    return r;
  endfunction

  task automatic send_word(mode_e m, logic [7:0] d, bit typed, word_t t);
    word_t e;
    e = decode_word(m, d);
    expected_q.push_back(typed ? t : e);
    items++;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= m;
    s_tdata <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic write_length(logic [31:0] v);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    len_cfg = v;
  endtask

  task automatic add_row(mode_e m, logic [7:0] d);
    rows.push_back('{1'b0, m, d, 32'd0, 1'b0, '{8'd0, 1'b0, 1'b0, 17'd0, ST_OK}});
  endtask

  task automatic add_typed(mode_e m, logic [7:0] d, status_e st, int pend);
    rows.push_back('{1'b0, m, d, 32'd0, 1'b1, '{8'd0, 1'b0, 1'b0, pend[16:0], st}});
  endtask

  task automatic add_cfg(logic [31:0] v);
    rows.push_back('{1'b1, MODE_NONE, 8'd0, v, 1'b0, '{8'd0, 1'b0, 1'b0, 17'd0, ST_OK}});
  endtask

  // msb-first code packer for the random streams
  longint unsigned acc;
  int              acc_n;
  byte unsigned    stream_q[$];

  function automatic void put_code(int unsigned code, int unsigned w);
    acc = (acc << w) | code;
    acc_n += w;
    while (acc_n >= 8) begin
      stream_q.push_back(byte'(acc >> (acc_n - 8)));
      acc_n -= 8;
      acc &= (64'd1 << acc_n) - 1;
    end
  endfunction

  function automatic void build_stream(bit noise);
    int unsigned gw, gnf, code, top, k, wp;
    bit lit;
    stream_q.delete();
    acc = 0; acc_n = 0;
    if (noise) begin
      k = $urandom_range(3, 12);
      repeat (k) stream_q.push_back(byte'($urandom_range(255)));
      return;
    end
    gw = MIN_WIDTH; gnf = CODE_FIRST; lit = 1'b1;
    wp = ($urandom_range(3) == 0) ? 25 : 4;
    k = $urandom_range(5, 40);
    repeat (k) begin
      if (lit) begin
        code = ($urandom_range(19) == 0) ? $urandom_range((1 << gw) - 1) : $urandom_range(255);
        lit = 1'b0;
        put_code(code, gw);
      end else if ($urandom_range(99) < wp) begin
        put_code(CODE_WIDEN, gw);
        if (gw < 16) gw++;
      end else if ($urandom_range(99) < 4) begin
        put_code(CODE_CLEAR, gw);
        gw = MIN_WIDTH; gnf = CODE_FIRST; lit = 1'b1;
      end else begin
        top = (gnf < (1 << gw) - 1) ? gnf : (1 << gw) - 1;
        if ($urandom_range(9) == 0 && gnf <= top) code = gnf;
        else if ($urandom_range(1) == 0 || top < CODE_FIRST) code = $urandom_range(255);
        else code = $urandom_range(top, CODE_FIRST);
        put_code(code, gw);
        if (gnf < 65536) gnf++;
      end
    end
    if (lit) put_code($urandom_range(255), gw);
    if ($urandom_range(7) != 0) put_code(CODE_END, gw);
    if (acc_n > 0) put_code(0, 8 - acc_n);
  endfunction

  task automatic run_session(bit noise);
    int idx;
    mode_e m;
    word_t none;
    none = '{8'd0, 1'b0, 1'b0, 17'd0, ST_OK};
    build_stream(noise);
    send_word(MODE_RESTART, 8'($urandom_range(255)), 1'b0, none);
    idx = 0;
    forever begin
      if (emitted >= len_cfg) begin
        send_word(mode_e'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, none);
        break;
      end
      if (sdepth > 200) break;
      if ($urandom_range(99) < 5) begin
        m = mode_e'($urandom_range(3));
        if (m != MODE_RESTART) send_word(m, 8'($urandom_range(255)), 1'b0, none);
      end else if (sdepth > 0) send_word(MODE_FETCH, 8'($urandom_range(255)), 1'b0, none);
      else if (idx < stream_q.size()) begin
        send_word(MODE_FEED, stream_q[idx], 1'b0, none);
        idx++;
      end else begin
        send_word(MODE_FETCH, 8'($urandom_range(255)), 1'b0, none);
        break;
      end
    end
  endtask

  // output side: random stalls, one long hold on request
  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h user %b last %b",
                                   m_tdata, m_tuser, m_tlast);
      end else begin
        word_t e;
        e = expected_q.pop_front();
        if (m_tdata[7:0] !== e.ob || m_tuser !== e.valid || m_tlast !== e.last ||
            m_tdata[24:8] !== e.pend || m_tdata[27:25] !== e.st ||
            m_tdata[31:28] !== 4'd0) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp byte %h valid %b last %b pend %0d status %0d,",
                      " got %h %b %b %0d %0d"},
                     e.ob, e.valid, e.last, e.pend, e.st, m_tdata[7:0], m_tuser, m_tlast,
                     m_tdata[24:8], m_tdata[27:25]);
        end
      end
    end
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #200ms;
    $display("lzw_stream_decompressor test failed");
    $finish;
  end

  initial begin
    int s;
    len_cfg = 0;
    restart_decoder();
    // after reset the length is zero
    add_typed(MODE_FETCH, 8'h00, ST_LEN, 0);
    add_typed(MODE_FEED, 8'hff, ST_LEN, 0);
    add_typed(MODE_NONE, 8'haa, ST_OK, 0);
    add_typed(MODE_RESTART, 8'h55, ST_OK, 0);
    add_cfg(32'hffff_ffff);
    // codes A, B, 259, kwkwk 261, end
    add_row(MODE_FEED, 8'h20);
    add_row(MODE_FEED, 8'h90);
    add_typed(MODE_FEED, 8'h00, ST_REFUSED, 1);
    add_row(MODE_FETCH, 8'h00);
    add_row(MODE_FEED, 8'ha0);
    add_row(MODE_FETCH, 8'h00);
    add_row(MODE_FEED, 8'h70);
    add_row(MODE_FETCH, 8'h00);
    add_row(MODE_FETCH, 8'h00);
    add_row(MODE_FEED, 8'h58);
    repeat (3) add_row(MODE_FETCH, 8'h00);
    add_row(MODE_FEED, 8'h00);
    add_typed(MODE_FEED, 8'h55, ST_REFUSED, 0);
    add_typed(MODE_FETCH, 8'h00, ST_END, 0);
    add_typed(MODE_RESTART, 8'h00, ST_OK, 0);
    add_cfg(32'd1);
    add_row(MODE_FEED, 8'h20);
    add_row(MODE_FEED, 8'h90);
    add_row(MODE_FETCH, 8'h00);
    add_typed(MODE_FETCH, 8'h00, ST_LEN, 0);
    add_typed(MODE_RESTART, 8'h00, ST_OK, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_length(rows[i].cfg);
      else send_word(rows[i].mode, rows[i].data, rows[i].typed, rows[i].exp);
    end

    s = 0;
    while (items < 640) begin
      if (s % 6 == 0) begin
        case ((s / 6) % 4)
          0: write_length(32'hffff_ffff);
          1: write_length($urandom_range(60, 1));
          2: write_length(32'd0);
          default: write_length($urandom_range(400, 20));
        endcase
      end
      case (s % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 71; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 71; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (s == 4) hold_req = 1'b1;
      run_session($urandom_range(4) == 0);
      s++;
    end
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("lzw_stream_decompressor test passed");
    else $display("lzw_stream_decompressor test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzwd_ctrl.sv
rtl/lzwd_datapath.sv
rtl/lzw_stream_decompressor.sv
dv/tb_lzw_stream_decompressor.sv
